// ----- rtl/core/pfc_pkg.sv -----
// shared types, command codes and square arithmetic for the playfair cipher
`timescale 1ns / 1ps

package pfc_pkg;

  localparam logic [2:0] CMD_CLEAR = 3'd0;
  localparam logic [2:0] CMD_KEY   = 3'd1;
  localparam logic [2:0] CMD_SEAL  = 3'd2;
  localparam logic [2:0] CMD_TEXT  = 3'd3;
  localparam logic [2:0] CMD_END   = 3'd4;

  localparam logic [4:0] LETTER_X     = 5'd23;
  localparam logic [4:0] LETTER_J     = 5'd9;
  localparam logic [4:0] LETTER_I     = 5'd8;
  localparam logic [4:0] LETTER_LAST  = 5'd25;
  localparam logic [4:0] SQUARE_CELLS = 5'd25;
  localparam int         ALPHABET     = 26;
  localparam int         CELLS        = 25;

  typedef struct packed {
    logic capture;
    logic clear_key;
    logic place_key;
    logic seal_start;
    logic seal_step;
    logic hold_text;
    logic pair_text;
    logic pair_end;
    logic rd_pa;
    logic rd_pb;
    logic calc;
    logic rd_k1;
    logic rd_k2;
    logic latch_k2;
    logic out_first;
    logic out_second;
  } pfc_cmd_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       is_letter;
    logic       sealed;
    logic       held_valid;
    logic       seal_last;
    logic       out_free;
  } pfc_stat_t;

  function automatic logic is_letter(input logic [7:0] b);
    return ((b >= 8'd65) && (b <= 8'd90)) || ((b >= 8'd97) && (b <= 8'd122));
  endfunction

  function automatic logic [4:0] letter_idx(input logic [7:0] b);
    logic [7:0] t;
    begin
      if (b <= 8'd90) t = b - 8'd65;
      else t = b - 8'd97;
      return t[4:0];
    end
  endfunction

  function automatic logic [2:0] row_of(input logic [4:0] p);
    logic [2:0] r;
    begin
      if (p < 5'd5) r = 3'd0;
      else if (p < 5'd10) r = 3'd1;
      else if (p < 5'd15) r = 3'd2;
      else if (p < 5'd20) r = 3'd3;
      else r = 3'd4;
      return r;
    end
  endfunction

  function automatic logic [2:0] col_of(input logic [4:0] p);
    logic [2:0] r;
    logic [4:0] t;
    begin
      r = row_of(p);
      t = p - {r, 2'b00} - {2'b00, r};
      return t[2:0];
    end
  endfunction

  // plus one when encrypting, minus one when decrypting, mod 5
  function automatic logic [2:0] step_of(input logic [2:0] v, input logic dec);
    logic [2:0] s;
    begin
      if (!dec) s = (v >= 3'd4) ? 3'd0 : v + 3'd1;
      else s = (v == 3'd0) ? 3'd4 : v - 3'd1;
      return s;
    end
  endfunction

  function automatic logic [4:0] cell_of(input logic [2:0] r, input logic [2:0] c);
    return {r, 2'b00} + {2'b00, r} + {2'b00, c};
  endfunction

endpackage

// ----- rtl/core/pfc_ctrl.sv -----
// command sequencer for the playfair cipher
`timescale 1ns / 1ps

module pfc_ctrl
  import pfc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  pfc_stat_t stat,
  output pfc_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SEAL,
    S_RD_A,
    S_RD_B,
    S_CALC,
    S_RD_K1,
    S_RD_K2,
    S_LATCH,
    S_EMIT1,
    S_EMIT2
  } state_t;

  state_t state;
  state_t state_next;
  logic   ready;

  assign in_ready = ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid && ready) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_IDLE;
        case (stat.cmd)
          CMD_CLEAR: cmd.clear_key = 1'b1;
          CMD_KEY:   cmd.place_key = 1'b1;
          CMD_SEAL: begin
            if (!stat.sealed) begin
              cmd.seal_start = 1'b1;
              state_next     = S_SEAL;
            end
          end
          CMD_TEXT: begin
            if (stat.is_letter) begin
              if (!stat.sealed) begin
                cmd.seal_start = 1'b1;
                state_next     = S_SEAL;
              end else if (!stat.held_valid) begin
                cmd.hold_text = 1'b1;
              end else begin
                cmd.pair_text = 1'b1;
                state_next    = S_RD_A;
              end
            end
          end
          CMD_END: begin
            if (stat.held_valid) begin
              if (!stat.sealed) begin
                cmd.seal_start = 1'b1;
                state_next     = S_SEAL;
              end else begin
                cmd.pair_end = 1'b1;
                state_next   = S_RD_A;
              end
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_SEAL: begin
        cmd.seal_step = 1'b1;
        if (stat.seal_last) state_next = S_DECODE;
      end
      S_RD_A: begin
        cmd.rd_pa  = 1'b1;
        state_next = S_RD_B;
      end
      S_RD_B: begin
        cmd.rd_pb  = 1'b1;
        state_next = S_CALC;
      end
      S_CALC: begin
        cmd.calc   = 1'b1;
        state_next = S_RD_K1;
      end
      S_RD_K1: begin
        cmd.rd_k1  = 1'b1;
        state_next = S_RD_K2;
      end
      S_RD_K2: begin
        cmd.rd_k2  = 1'b1;
        state_next = S_LATCH;
      end
      S_LATCH: begin
        cmd.latch_k2 = 1'b1;
        state_next   = S_EMIT1;
      end
      S_EMIT1: begin
        if (stat.out_free) begin
          cmd.out_first = 1'b1;
          state_next    = S_EMIT2;
        end
      end
      S_EMIT2: begin
        if (stat.out_free) begin
          cmd.out_second = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ready <= 1'b1;
    end else begin
      state <= state_next;
      ready <= (state_next == S_IDLE);
    end
  end

endmodule

// ----- rtl/core/pfc_datapath.sv -----
// key square stores, letter pairing and digraph transform for the playfair cipher
`timescale 1ns / 1ps

module pfc_datapath
  import pfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic [7:0] in_byte,
  input  logic [2:0] in_cmd,
  input  pfc_cmd_t   cmd,
  output pfc_stat_t  stat,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] out_letter,
  output logic       out_last
);

  logic [2:0]  item_cmd;
  logic [7:0]  item_byte;
  logic        direction;
  logic [ALPHABET-1:0] taken;
  logic [4:0]  fill;
  logic        sealed;
  logic [4:0]  held_letter;
  logic        held_valid;
  logic [4:0]  scan;

  logic [4:0]  key_mem [CELLS];
  logic [4:0]  place_mem [ALPHABET];
  logic [4:0]  place_q;
  logic [4:0]  key_q;

  logic [4:0]  pair_a;
  logic [4:0]  pair_b;
  logic [4:0]  pa;
  logic [4:0]  cell1;
  logic [4:0]  cell2;
  logic [4:0]  k1;
  logic [4:0]  k2;

  logic        item_ok;
  logic [4:0]  item_idx;
  logic [4:0]  text_idx;
  logic        wr_en;
  logic [4:0]  wr_letter;
  logic        room;
  logic [4:0]  place_addr;
  logic [4:0]  key_addr;

  logic [2:0]  r1;
  logic [2:0]  c1;
  logic [2:0]  r2;
  logic [2:0]  c2;
  logic [2:0]  r1_n;
  logic [2:0]  c1_n;
  logic [2:0]  r2_n;
  logic [2:0]  c2_n;

  assign item_ok  = is_letter(item_byte);
  assign item_idx = letter_idx(item_byte);
  assign text_idx = (item_idx == LETTER_J) ? LETTER_I : item_idx;
  assign room     = (fill < SQUARE_CELLS);

  always_comb begin
    wr_en     = 1'b0;
    wr_letter = item_idx;
    if (cmd.place_key && !sealed && item_ok && !taken[item_idx] && room) begin
      wr_en = 1'b1;
    end
    if (cmd.seal_step && !taken[scan] && room) begin
      wr_en     = 1'b1;
      wr_letter = scan;
    end
  end

  assign stat.cmd        = item_cmd;
  assign stat.is_letter  = item_ok;
  assign stat.sealed     = sealed;
  assign stat.held_valid = held_valid;
  assign stat.seal_last  = (scan == LETTER_LAST);
  assign stat.out_free   = !out_valid || out_ready;

  // square stores
  assign place_addr = cmd.rd_pa ? pair_a : pair_b;
  assign key_addr   = cmd.rd_k1 ? cell1 : cell2;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[fill]        <= wr_letter;
      place_mem[wr_letter] <= fill;
    end
    if (cmd.rd_pa || cmd.rd_pb) place_q <= place_mem[place_addr];
    if (cmd.rd_k1 || cmd.rd_k2) key_q <= key_mem[key_addr];
  end

  // digraph rules
  always_comb begin
    r1   = row_of(pa);
    c1   = col_of(pa);
    r2   = row_of(place_q);
    c2   = col_of(place_q);
    r1_n = r1;
    c1_n = c1;
    r2_n = r2;
    c2_n = c2;
    if (r1 == r2) begin
      c1_n = step_of(c1, direction);
      c2_n = step_of(c2, direction);
    end else if (c1 == c2) begin
      r1_n = step_of(r1, direction);
      r2_n = step_of(r2, direction);
    end else begin
      c1_n = c2;
      c2_n = c1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_cmd  <= in_cmd;
      item_byte <= in_byte;
    end
    if (cmd.pair_text) begin
      pair_a <= held_letter;
      pair_b <= (!direction && held_letter == text_idx) ? LETTER_X : text_idx;
    end
    if (cmd.pair_end) begin
      pair_a <= held_letter;
      pair_b <= LETTER_X;
    end
    if (cmd.rd_pb) pa <= place_q;
    if (cmd.calc) begin
      cell1 <= cell_of(r1_n, c1_n);
      cell2 <= cell_of(r2_n, c2_n);
    end
    if (cmd.rd_k2) k1 <= key_q;
    if (cmd.latch_k2) k2 <= key_q;
    if (cmd.out_first) begin
      out_letter <= 7'd65 + {2'b00, k1};
      out_last   <= 1'b0;
    end
    if (cmd.out_second) begin
      out_letter <= 7'd65 + {2'b00, k2};
      out_last   <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      direction   <= 1'b0;
      taken       <= ALPHABET'(1) << LETTER_J;
      fill        <= '0;
      sealed      <= 1'b0;
      held_letter <= '0;
      held_valid  <= 1'b0;
      scan        <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) direction <= cfg_wdata;
      if (cmd.clear_key) begin
        taken       <= ALPHABET'(1) << LETTER_J;
        fill        <= '0;
        sealed      <= 1'b0;
        held_letter <= '0;
        held_valid  <= 1'b0;
      end
      if (wr_en) begin
        taken[wr_letter] <= 1'b1;
        fill             <= fill + 5'd1;
      end
      if (cmd.seal_start) scan <= '0;
      if (cmd.seal_step) begin
        scan <= scan + 5'd1;
        if (scan == LETTER_LAST) sealed <= 1'b1;
      end
      if (cmd.hold_text) begin
        held_letter <= text_idx;
        held_valid  <= 1'b1;
      end
      if (cmd.pair_text) begin
        held_letter <= text_idx;
        held_valid  <= !direction && (held_letter == text_idx);
      end
      if (cmd.pair_end) held_valid <= 1'b0;
      out_valid <= cmd.out_first || cmd.out_second || (out_valid && !out_ready);
    end
  end

endmodule

// ----- rtl/core/playfair_digraph_cipher.sv -----
// a key, clear or unpaired text word passes through capture and decode before the next accept
// sealing the square scans the alphabet one letter a cycle, from A to Z
// a text word that completes a pair reads both places and then both key letters, one at a time
// through the single read port of each store, before it gives the first letter and then the second
// rst (synchronous, active high) empties the square, clears the held letter and
// sets direction to encrypt; the square stores keep their contents
`timescale 1ns / 1ps

module playfair_digraph_cipher
  import pfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,        // direction
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,     // data_byte
  input  logic [2:0] s_axis_tuser,     // command
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,     // cipher_letter, zero pad
  output logic       m_axis_tlast
);

  pfc_cmd_t   cmd;
  pfc_stat_t  stat;
  logic [6:0] letter;

  assign m_axis_tdata = {1'b0, letter};

  pfc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pfc_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_byte    (s_axis_tdata),
    .in_cmd     (s_axis_tuser),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_letter (letter),
    .out_last   (m_axis_tlast)
  );

endmodule

// ----- test/playfair_digraph_cipher_tb.sv -----
// self-checking testbench for the playfair digraph cipher with a built-in predictor
`timescale 1ns / 1ps

module playfair_digraph_cipher_tb;
  import pfc_pkg::*;

  localparam int WATCHDOG_CYCLES = 3000;
  localparam int SETTLE_CYCLES   = 40;
  localparam int RX_HOLD_CYCLES  = 400;
  localparam int RANDOM_WORDS    = 760;

  localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic [6:0] letter;
    logic       last;
  } cipher_out_t;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_SPARSE} rx_mode_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic       cfg_wdata = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'd0;    // data_byte
  logic [2:0] s_axis_tuser = 3'd0;    // command
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // cipher_letter, zero pad
  logic       m_axis_tlast;

  // predictor state
  logic [4:0] sq_cell [25];
  logic [4:0] sq_place [26];
  logic       sq_taken [26];
  int         sq_fill;
  bit         sq_sealed;
  logic [4:0] pend_letter;
  bit         pend_valid;
  bit         dir_dec;

  cipher_out_t cipher_q[$];

  int       words_sent = 0;
  int       letters_checked = 0;
  int       bad_letters = 0;
  int       dir_writes = 0;
  int       stall_cycles = 0;
  int       burst_left = 0;
  bit       sender_steady = 1'b0;
  bit       rx_hold_start = 1'b0;
  rx_mode_t rx_mode = RX_ALWAYS;

  playfair_digraph_cipher i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int letter_of(input logic [7:0] b);
    if (b >= 8'd65 && b <= 8'd90) return int'(b) - 65;
    if (b >= 8'd97 && b <= 8'd122) return int'(b) - 97;
    return -1;
  endfunction

  function automatic void forget_key();
    for (int i = 0; i < 26; i++) sq_taken[i] = 1'b0;
    sq_taken[LETTER_J] = 1'b1;
    sq_fill = 0;
    sq_sealed = 1'b0;
    pend_letter = 5'd0;
    pend_valid = 1'b0;
  endfunction

  function automatic void set_cell(input int l);
    if (sq_fill < 25) begin
      sq_cell[sq_fill] = l[4:0];
      sq_place[l] = sq_fill[4:0];
      sq_taken[l] = 1'b1;
      sq_fill++;
    end
  endfunction

  function automatic void complete_square();
    if (!sq_sealed) begin
      for (int l = 0; l < 26; l++)
        if (!sq_taken[l]) set_cell(l);
      sq_sealed = 1'b1;
    end
  endfunction

  function automatic void push_digraph(input logic [4:0] a, input logic [4:0] b);
    int pa, pb, r1, c1, r2, c2, shift, t;
    cipher_out_t o;
    pa = sq_place[a];
    pb = sq_place[b];
    r1 = pa / 5;
    c1 = pa % 5;
    r2 = pb / 5;
    c2 = pb % 5;
    shift = dir_dec ? 4 : 1;
    if (r1 == r2) begin
      c1 = (c1 + shift) % 5;
      c2 = (c2 + shift) % 5;
    end else if (c1 == c2) begin
      r1 = (r1 + shift) % 5;
      r2 = (r2 + shift) % 5;
    end else begin
      t = c1;
      c1 = c2;
      c2 = t;
    end
    o.letter = 7'd65 + {2'b00, sq_cell[r1 * 5 + c1]};
    o.last = 1'b0;
    cipher_q.push_back(o);
    o.letter = 7'd65 + {2'b00, sq_cell[r2 * 5 + c2]};
    o.last = 1'b1;
    cipher_q.push_back(o);
  endfunction

  function automatic void predict_word(input logic [2:0] cmd, input logic [7:0] data);
    int l;
    l = letter_of(data);
    case (cmd)
      CMD_CLEAR: forget_key();
      CMD_KEY: if (!sq_sealed && l >= 0 && !sq_taken[l]) set_cell(l);
      CMD_SEAL: complete_square();
      CMD_TEXT: begin
        if (l >= 0) begin
          complete_square();
          if (l == LETTER_J) l = LETTER_I;
          if (!pend_valid) begin
            pend_letter = l[4:0];
            pend_valid = 1'b1;
          end else if (!dir_dec && pend_letter == l[4:0]) begin
            push_digraph(pend_letter, LETTER_X);
            pend_letter = l[4:0];
          end else begin
            push_digraph(pend_letter, l[4:0]);
            pend_valid = 1'b0;
          end
        end
      end
      CMD_END: begin
        if (pend_valid) begin
          complete_square();
          push_digraph(pend_letter, LETTER_X);
          pend_valid = 1'b0;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [7:0] letter_byte(input int l);
    return ($urandom_range(0, 1) ? 8'd97 : 8'd65) + l[7:0];
  endfunction

  task automatic send_word(input logic [2:0] cmd, input logic [7:0] data);
    int gap;
    if (!sender_steady && burst_left == 0) begin
      gap = $urandom_range(1, 10);
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= data;
    s_axis_tuser <= cmd;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_word(cmd, data);
    words_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(CMD_TEXT, s[i]);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (cipher_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_direction(input bit dec);
    wait_idle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= dec;
    @(posedge clk);
    dir_dec = dec;
    dir_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // key bytes straight after reset, filtering, sealing and encrypt cases
  task automatic test_directed();
    set_direction(1'b0);
    send_word(CMD_KEY, "P");
    send_word(CMD_KEY, "l");
    send_word(CMD_KEY, "J");
    send_word(CMD_KEY, "p");
    send_word(CMD_KEY, 8'h40);
    send_word(CMD_KEY, 8'h5B);
    send_word(CMD_KEY, 8'h60);
    send_word(CMD_KEY, 8'h7B);
    send_word(CMD_KEY, 8'hFF);
    send_word(CMD_KEY, 8'h00);
    send_word(CMD_KEY, "Z");
    send_word(CMD_KEY, "a");
    send_word(CMD_SEAL, 8'h00);
    send_word(CMD_SEAL, 8'h00);
    send_word(CMD_KEY, "Q");
    send_text("HjeExXX");
    send_word(CMD_END, 8'h00);
    send_word(CMD_END, 8'h00);
    send_word(CMD_SPARE_FIRST, "A");
    send_word(CMD_SPARE_LAST, 8'hFF);
    send_text("1z");
    send_word(CMD_END, 8'h00);
  endtask

  // text arriving on an unsealed square seals it first
  task automatic test_text_before_seal();
    send_word(CMD_CLEAR, 8'h00);
    send_word(CMD_END, 8'h00);
    send_text("keY");
    send_word(CMD_CLEAR, 8'h00);
    send_word(CMD_KEY, "k");
    send_word(CMD_KEY, "e");
    send_word(CMD_KEY, "y");
    send_text("World");
    send_word(CMD_END, 8'h00);
    send_word(CMD_CLEAR, 8'h00);
    send_text("m");
    send_word(CMD_CLEAR, 8'h00);
    send_text("NO");
  endtask

  // decrypt keeps doubled letters, then back to encrypt
  task automatic test_direction();
    set_direction(1'b1);
    send_word(CMD_CLEAR, 8'h00);
    send_text("Monarchy");
    send_word(CMD_SEAL, 8'h00);
    send_word(CMD_CLEAR, 8'h00);
    send_word(CMD_KEY, "M");
    send_word(CMD_KEY, "o");
    send_word(CMD_KEY, "n");
    send_word(CMD_SEAL, 8'h00);
    send_text("EEjIxxQ");
    send_word(CMD_END, 8'h00);
    set_direction(1'b0);
    send_text("EEjIxxQ");
    send_word(CMD_END, 8'h00);
  endtask

  // receiver holds off while the sender keeps offering text
  task automatic test_backpressure();
    sender_steady = 1'b1;
    rx_hold_start = 1'b1;
    for (int i = 0; i < 60; i++) send_word(CMD_TEXT, letter_byte($urandom_range(0, 25)));
    send_word(CMD_END, 8'h00);
    sender_steady = 1'b0;
  endtask

  task automatic random_message();
    int n;
    int l;
    int prev;
    if ($urandom_range(0, 9) != 0) send_word(CMD_CLEAR, 8'($urandom_range(0, 255)));
    n = $urandom_range(0, 12);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) send_word(CMD_KEY, 8'($urandom_range(0, 255)));
      else send_word(CMD_KEY, letter_byte($urandom_range(0, 25)));
    end
    if ($urandom_range(0, 1)) send_word(CMD_SEAL, 8'($urandom_range(0, 255)));
    n = $urandom_range(1, 14);
    prev = $urandom_range(0, 25);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: send_word(CMD_TEXT, 8'($urandom_range(0, 255)));
        1, 2: send_word(CMD_TEXT, letter_byte(prev));
        default: begin
          l = $urandom_range(0, 25);
          send_word(CMD_TEXT, letter_byte(l));
          prev = l;
        end
      endcase
      if ($urandom_range(0, 29) == 0)
        send_word(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 3) != 0) send_word(CMD_END, 8'($urandom_range(0, 255)));
  endtask

  task automatic test_random();
    int target;
    target = words_sent + RANDOM_WORDS;
    while (words_sent < target) begin
      if ($urandom_range(0, 5) == 0) set_direction(1'($urandom_range(0, 1)));
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      sender_steady = ($urandom_range(0, 4) == 0);
      random_message();
    end
    sender_steady = 1'b0;
  endtask

  initial begin : rx_pattern
    int hold_left;
    int tick;
    hold_left = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      tick++;
      if (rx_hold_start) begin
        hold_left = RX_HOLD_CYCLES;
        rx_hold_start = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS: m_axis_tready <= 1'b1;
          RX_RANDOM: m_axis_tready <= ($urandom_range(0, 3) != 0);
          RX_PATTERN: m_axis_tready <= ((tick % 5) != 0) && ((tick % 7) != 3);
          default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_letters
    cipher_out_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      letters_checked++;
      if (cipher_q.size() == 0) begin
        if (bad_letters < 10)
          $display("unexpected word: tdata=%h tlast=%b", m_axis_tdata, m_axis_tlast);
        bad_letters++;
      end else begin
        want = cipher_q.pop_front();
        if (m_axis_tdata !== {1'b0, want.letter} || m_axis_tlast !== want.last) begin
          if (bad_letters < 10)
            $display("mismatch: expected tdata=%h tlast=%b, got tdata=%h tlast=%b",
                     {1'b0, want.letter}, want.last, m_axis_tdata, m_axis_tlast);
          bad_letters++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_CYCLES) begin
      $display("playfair_digraph_cipher_tb: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < 25; i++) sq_cell[i] = 5'd0;
    for (int i = 0; i < 26; i++) sq_place[i] = 5'd0;
    dir_dec = 1'b0;
    forget_key();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_text_before_seal();
    test_direction();
    test_backpressure();
    test_random();
    wait_idle();
    $display("sent %0d words, checked %0d cipher letters over %0d direction writes",
             words_sent, letters_checked, dir_writes);
    $display("covered key filtering, sealing, both directions and receiver stalls");
    if (bad_letters == 0 && cipher_q.size() == 0) begin
      $display("playfair_digraph_cipher_tb: PASS");
    end else begin
      $display("%0d mismatches, %0d letters still expected", bad_letters, cipher_q.size());
      $display("playfair_digraph_cipher_tb: FAIL");
    end
    $finish;
  end

endmodule
